/* design/bkra_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkra_pkg
// Shared types, key codes and character lookup for the boot keyboard report
// decoder.
// ----------------------------------------------------------------------------
package bkra_pkg;

   // Geometry of one boot report.
   localparam int NUM_SLOTS        = 6;
   localparam int MIN_REPORT_LEN   = 8;
   localparam int BKRA_QUEUE_DEPTH = 2;

   // Usage codes with special handling.
   localparam logic [7:0] KEY_ROLLOVER = 8'h01;
   localparam logic [7:0] KEY_CAPS     = 8'h39;
   localparam logic [7:0] KEY_F1       = 8'h3A;
   localparam logic [7:0] KEY_F2       = 8'h3B;
   localparam logic [7:0] KEY_F11      = 8'h44;
   localparam logic [7:0] KEY_F12      = 8'h45;
   localparam logic [7:0] KEY_SCROLL   = 8'h47;
   localparam logic [7:0] KEY_PAUSE    = 8'h48;
   localparam logic [7:0] LETTER_FIRST = 8'h04;
   localparam logic [7:0] LETTER_LAST  = 8'h1D;
   localparam logic [7:0] PUNCT_FIRST  = 8'h1E;
   localparam logic [7:0] PUNCT_LAST   = 8'h38;

   // Modifier masks.
   localparam logic [7:0] MOD_CTRL  = 8'h11;
   localparam logic [7:0] MOD_SHIFT = 8'h22;

   // Event kinds carried on the result channel.
   typedef enum logic [1:0] {
      EV_CHAR = 2'd0,
      EV_EXIT = 2'd1,
      EV_DUMP = 2'd2
   } event_kind_type;

   // One classified report: a mask of slots that produce an event and the
   // event contents for every slot.
   typedef struct packed {
      logic [NUM_SLOTS-1:0]                 mask;
      logic [NUM_SLOTS-1:0][1:0]            kind;
      logic [NUM_SLOTS-1:0][6:0]            chr;
   } report_entry_type;

   // Characters for usages 0x1E..0x38, unshifted and shifted.
   localparam logic [6:0] PUNCT_BASE [27] = '{
      7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
      7'h0A, 7'h1B, 7'h08, 7'h09, 7'h20,
      7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C, 7'h00, 7'h3B, 7'h27, 7'h60, 7'h2C,
      7'h2E, 7'h2F
   };
   localparam logic [6:0] PUNCT_SHIFT [27] = '{
      7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
      7'h0A, 7'h1B, 7'h08, 7'h09, 7'h20,
      7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C, 7'h00, 7'h3A, 7'h22, 7'h7E, 7'h3C,
      7'h3E, 7'h3F
   };

   // Character for a usage, or zero when the usage has none.
   function automatic logic [6:0] usage_char(input logic [7:0] u,
                                             input logic       shift,
                                             input logic       caps,
                                             input logic       ctrl);
      logic [7:0] c;
      logic [4:0] idx;
      c   = 8'h00;
      idx = 5'(u - PUNCT_FIRST);
      if (u >= LETTER_FIRST && u <= LETTER_LAST) begin
         c = (shift ? 8'h41 : 8'h61) + (u - LETTER_FIRST);
         if (caps) begin
            c = c ^ 8'h20;
         end
         if (ctrl) begin
            c = c & 8'h1F;
         end
      end else if (u >= PUNCT_FIRST && u <= PUNCT_LAST) begin
         c = {1'b0, (shift ? PUNCT_SHIFT[idx] : PUNCT_BASE[idx])};
      end
      return c[6:0];
   endfunction

endpackage

/* design/bkra_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkra_front
// Accepts reports, finds newly pressed keys against the previous key set,
// tracks caps lock and builds a ready-made event for each slot that has one.
// ----------------------------------------------------------------------------
module bkra_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic [4:0]                  report_length,
   input  logic [7:0]                  modifiers,
   input  logic [5:0][7:0]             slots,
   output logic                        push,
   output bkra_pkg::report_entry_type  entry
);
   import bkra_pkg::*;

   logic [NUM_SLOTS-1:0][7:0] prev_keys_ff;
   logic [NUM_SLOTS-1:0][7:0] prev_keys_in;
   logic                      caps_ff;
   logic                      caps_in;

   logic                      report_ok;
   logic                      shift;
   logic                      ctrl;

   // Classify all six slots; caps lock toggles apply to later slots.
   always_comb begin
      logic             rollover;
      logic             held;
      logic             is_new;
      logic             caps_run;
      logic [6:0]       ch;
      rollover  = 1'b1;
      caps_run  = caps_ff;
      shift     = (modifiers & MOD_SHIFT) != 8'h00;
      ctrl      = (modifiers & MOD_CTRL) != 8'h00;
      entry     = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (slots[i] != KEY_ROLLOVER) begin
            rollover = 1'b0;
         end
      end
      report_ok = (report_length >= 5'(MIN_REPORT_LEN)) && !rollover;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         held = 1'b0;
         for (int j = 0; j < NUM_SLOTS; j++) begin
            if (prev_keys_ff[j] == slots[i]) begin
               held = 1'b1;
            end
         end
         is_new = (slots[i] != 8'h00) && !held;
         ch     = usage_char(slots[i], shift, caps_run, ctrl);
         if (is_new && slots[i] == KEY_CAPS) begin
            caps_run = !caps_run;
         end else if (is_new && (slots[i] == KEY_F2 || slots[i] == KEY_F12 ||
                                 slots[i] == KEY_PAUSE)) begin
            entry.mask[i] = 1'b1;
            entry.kind[i] = EV_EXIT;
         end else if (is_new && (slots[i] == KEY_F1 || slots[i] == KEY_F11 ||
                                 slots[i] == KEY_SCROLL)) begin
            entry.mask[i] = 1'b1;
            entry.kind[i] = EV_DUMP;
         end else if (is_new && ch != 7'h00) begin
            entry.mask[i] = 1'b1;
            entry.kind[i] = EV_CHAR;
            entry.chr[i]  = ch;
         end
      end
      caps_in      = caps_ff;
      prev_keys_in = prev_keys_ff;
      if (take && report_ok) begin
         caps_in      = caps_run;
         prev_keys_in = slots;
      end
   end

   // Only reports that produce at least one event go to the queue.
   assign push = take && report_ok && (entry.mask != '0);

   // Key set and caps lock state.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_keys_ff <= '0;
         caps_ff      <= 1'b0;
      end else begin
         prev_keys_ff <= prev_keys_in;
         caps_ff      <= caps_in;
      end
   end

endmodule

/* design/bkra_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkra_queue
// Small first-in first-out queue of classified reports between the front
// and the back.
// ----------------------------------------------------------------------------
module bkra_queue #(
   parameter int DEPTH = bkra_pkg::BKRA_QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  bkra_pkg::report_entry_type  push_entry,
   input  logic                        pop,
   output logic                        full,
   output logic                        not_empty,
   output bkra_pkg::report_entry_type  head_entry
);
   import bkra_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   report_entry_type   slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign not_empty  = count_ff != '0;
   assign head_entry = slots_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* design/bkra_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkra_back
// Drains one classified report at a time, sending its events in slot order
// through a registered output stage and marking the final one.
// ----------------------------------------------------------------------------
module bkra_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  bkra_pkg::report_entry_type  q_entry,
   output logic                        q_pop,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [1:0]                  out_kind,
   output logic [6:0]                  out_char,
   output logic                        out_last
);
   import bkra_pkg::*;

   logic [NUM_SLOTS-1:0]  mask_ff;
   logic [NUM_SLOTS-1:0]  mask_in;
   report_entry_type      cur_ff;
   logic                  valid_ff;
   logic                  valid_in;
   logic [1:0]            kind_ff;
   logic [6:0]            char_ff;
   logic                  last_ff;

   logic                  advance;
   logic [NUM_SLOTS-1:0]  low_bit;
   logic [NUM_SLOTS-1:0]  rest;
   logic [1:0]            pick_kind;
   logic [6:0]            pick_char;

   // Lowest pending slot and its event.
   always_comb begin
      logic found;
      found     = 1'b0;
      low_bit   = '0;
      pick_kind = '0;
      pick_char = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (mask_ff[i] && !found) begin
            found      = 1'b1;
            low_bit[i] = 1'b1;
            pick_kind  = cur_ff.kind[i];
            pick_char  = cur_ff.chr[i];
         end
      end
   end

   assign rest    = mask_ff & ~low_bit;
   assign advance = (mask_ff != '0) && (!valid_ff || out_ready);
   assign q_pop   = q_valid && ((mask_ff == '0) || (advance && rest == '0));

   // Pending mask and output valid.
   always_comb begin
      mask_in  = mask_ff;
      valid_in = valid_ff;
      if (advance) begin
         mask_in  = rest;
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
      if (q_pop) begin
         mask_in = q_entry.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_entry;
      end
      if (advance) begin
         kind_ff <= pick_kind;
         char_ff <= pick_char;
         last_ff <= rest == '0;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

endmodule

/* design/boot_keyboard_report_to_ascii.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boot_keyboard_report_to_ascii
// Decodes USB boot keyboard reports into characters and hotkey events.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one 8-byte boot report per item. Reports shorter
//   than eight bytes and rollover-error reports are dropped without effect.
//   Each newly pressed key gives at most one item on the rsp channel: a
//   character, an emergency-exit hotkey or a status-dump hotkey, with
//   rsp_tlast on the final item of a report. Reports without events give
//   no output at all.
//   An accepted report passes through the report queue, the back end's
//   pending-mask register and the output register before its first event
//   appears. The back end sends one event per cycle while the receiver is
//   ready, and each queued report holds one to six events; the front takes
//   a report every cycle while the two-entry report queue has room.
//   A stalled receiver holds the output register; the queue then fills and
//   req_tready drops. Reset clears the previous key set, caps lock, the
//   queue and the output register; nothing further is needed before use.
// ----------------------------------------------------------------------------
module boot_keyboard_report_to_ascii #(
   parameter int QUEUE_DEPTH = bkra_pkg::BKRA_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: report_length[4:0], modifiers[12:5], key_slot_0[20:13],
   // key_slot_1[28:21], key_slot_2[36:29], key_slot_3[44:37],
   // key_slot_4[52:45], key_slot_5[60:53], zero fill[63:61].
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: char_code[6:0], zero fill[7].
   output logic [7:0]  rsp_tdata,
   // Fields from bit 0: event_kind[1:0].
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);
   import bkra_pkg::*;

   logic                  take;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_full;
   logic                  q_not_empty;
   report_entry_type      front_entry;
   report_entry_type      head_entry;
   logic [5:0][7:0]       slots;
   logic [6:0]            char_code;

   // Unpack the key slots.
   assign slots      = req_tdata[60:13];
   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready;

   bkra_front u_front (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .report_length (req_tdata[4:0]),
      .modifiers     (req_tdata[12:5]),
      .slots         (slots),
      .push          (q_push),
      .entry         (front_entry)
   );

   bkra_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (front_entry),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head_entry (head_entry)
   );

   bkra_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_entry   (head_entry),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_kind  (rsp_tuser),
      .out_char  (char_code),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, char_code};

`ifndef ASSERT_OFF
   // The front never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("report queue overflow");

   // Hotkey events carry no character.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != EV_CHAR) |-> rsp_tdata == 8'h00)
      else $error("hotkey event with a character");

   // Character events never carry a null character.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == EV_CHAR) |-> rsp_tdata != 8'h00)
      else $error("character event without a character");

   // The back only takes a report that is there.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_not_empty)
      else $error("pop from an empty report queue");
`endif

endmodule
